// ----- design/point_segment_distance_closest_top_macros.svh -----
// Assertion macros for the checker file psdc_checker.sv.
`ifndef POINT_SEGMENT_DISTANCE_CLOSEST_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_CLOSEST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSDC_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define PSDC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define PSDC_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// ----- design/psdc_pkg.sv -----
// ----------------------------------------------------------------------------
// psdc_pkg
// Region codes for the point-to-segment closest point block.
// ----------------------------------------------------------------------------
package psdc_pkg;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BEFORE   = 2'd1;
  localparam logic [1:0] REGION_PAST     = 2'd2;
  localparam logic [1:0] REGION_ZERO     = 2'd3;

endpackage

// ----- design/point_segment_distance_closest_top.sv -----
// ----------------------------------------------------------------------------
// point_segment_distance_closest_top
// Closest point on a 2D segment to a query point, and the truncated distance.
//
//   channel  dir  tdata fields (low bit up)                     tuser
//   s_*      in   point_x point_y source_x source_y target_x target_y  -
//   m_*      out  distance closest_x closest_y                  region
//
// One item per cycle while the pipe is not held. The pipe has 10 + T_FRAC_BITS +
// COORD_WIDTH + 2 register stages, set by the restoring divider (one quotient bit
// a stage) and the square root (one root bit a stage). The whole pipe advances on
// one enable; it holds while the output stage is full and m_tready is low.
// rst clears only the valid bits.
// ----------------------------------------------------------------------------
module point_segment_distance_closest_top #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // point_x, point_y, source_x, source_y, target_x, target_y
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // distance, closest_x, closest_y
  output logic [((3*COORD_WIDTH+2+7)/8)*8-1:0]    m_tdata,
  // region
  output logic [1:0]                              m_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int TF   = T_FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int TQW  = TF + 1;
  localparam int PXW  = TQW + 1 + DW;
  localparam int SW   = CW + 2;
  localparam int XW   = 2 * SW;
  localparam int RW   = SW + 2;
  localparam int NST  = 4 + TQW + 5 + SW;
  localparam int OUTW = ((3*CW+2+7)/8)*8;
  localparam int OPAD = OUTW - (3*CW+2);

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [DW-1:0] ddx;
    logic signed [DW-1:0] ddy;
    logic [1:0]           region;
    logic [PW-1:0]        den;
  } div_carry_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [1:0]           region;
  } sq_carry_t;

  logic             en;
  logic [NST-1:0]   vld;

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage A: input register
  logic signed [CW-1:0] a_px, a_py, a_sx, a_sy, a_tx, a_ty;
  always_ff @(posedge clk) begin
    if (en) begin
      a_px <= s_tdata[0*CW +: CW];
      a_py <= s_tdata[1*CW +: CW];
      a_sx <= s_tdata[2*CW +: CW];
      a_sy <= s_tdata[3*CW +: CW];
      a_tx <= s_tdata[4*CW +: CW];
      a_ty <= s_tdata[5*CW +: CW];
    end
  end

  // stage B: differences
  logic signed [CW-1:0] b_sx, b_sy, b_px, b_py;
  logic signed [DW-1:0] b_ddx, b_ddy, b_qx, b_qy;
  always_ff @(posedge clk) begin
    if (en) begin
      b_sx  <= a_sx;
      b_sy  <= a_sy;
      b_px  <= a_px;
      b_py  <= a_py;
      b_ddx <= {a_tx[CW-1], a_tx} - {a_sx[CW-1], a_sx};
      b_ddy <= {a_ty[CW-1], a_ty} - {a_sy[CW-1], a_sy};
      b_qx  <= {a_px[CW-1], a_px} - {a_sx[CW-1], a_sx};
      b_qy  <= {a_py[CW-1], a_py} - {a_sy[CW-1], a_sy};
    end
  end

  // stage C: products
  logic signed [CW-1:0]   c_sx, c_sy, c_px, c_py;
  logic signed [DW-1:0]   c_ddx, c_ddy;
  logic signed [2*DW-1:0] c_dxx, c_dyy, c_qdx, c_qdy;
  always_ff @(posedge clk) begin
    if (en) begin
      c_sx  <= b_sx;
      c_sy  <= b_sy;
      c_px  <= b_px;
      c_py  <= b_py;
      c_ddx <= b_ddx;
      c_ddy <= b_ddy;
      c_dxx <= b_ddx * b_ddx;
      c_dyy <= b_ddy * b_ddy;
      c_qdx <= b_qx * b_ddx;
      c_qdy <= b_qy * b_ddy;
    end
  end

  // stage D: sums and region decision
  logic [PW-1:0]        den_next;
  logic signed [PW-1:0] num_next;
  logic [1:0]           region_next;
  div_carry_t           d_carry;
  logic [PW-1:0]        d_r;

  always_comb begin
    den_next = {1'b0, c_dxx} + {1'b0, c_dyy};
    num_next = {c_qdx[2*DW-1], c_qdx} + {c_qdy[2*DW-1], c_qdy};
    if (den_next == '0) begin
      region_next = psdc_pkg::REGION_ZERO;
    end else if (num_next[PW-1]) begin
      region_next = psdc_pkg::REGION_BEFORE;
    end else if (num_next > den_next) begin
      region_next = psdc_pkg::REGION_PAST;
    end else begin
      region_next = psdc_pkg::REGION_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_carry.sx     <= c_sx;
      d_carry.sy     <= c_sy;
      d_carry.px     <= c_px;
      d_carry.py     <= c_py;
      d_carry.ddx    <= c_ddx;
      d_carry.ddy    <= c_ddy;
      d_carry.region <= region_next;
      d_carry.den    <= den_next;
      d_r            <= num_next;
    end
  end

  // stage E: restoring divider, one quotient bit a stage
  div_carry_t    e_carry [0:TF];
  logic [PW-1:0] e_r     [0:TF];
  logic [TQW-1:0] e_tq   [0:TF];

  for (genvar k = 0; k <= TF; k++) begin : g_div
    logic [PW-1:0]  r_in;
    logic [TQW-1:0] tq_in;
    div_carry_t     c_in;
    logic [PW:0]    rs;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_in  = d_r;
      assign tq_in = '0;
      assign c_in  = d_carry;
      assign rs    = {1'b0, r_in};
    end else begin : g_rest
      assign r_in  = e_r[k-1];
      assign tq_in = e_tq[k-1];
      assign c_in  = e_carry[k-1];
      assign rs    = {r_in, 1'b0};
    end

    assign ge = rs >= {1'b0, c_in.den};

    always_ff @(posedge clk) begin
      if (en) begin
        e_carry[k] <= c_in;
        e_r[k]     <= ge ? PW'(rs - {1'b0, c_in.den}) : rs[PW-1:0];
        e_tq[k]    <= {tq_in[TQW-2:0], ge};
      end
    end
  end

  // stage F: scale the direction by the quotient
  div_carry_t           e_last;
  logic [TQW-1:0]       tq_f;
  logic signed [CW-1:0] f_sx, f_sy, f_px, f_py;
  logic signed [PXW-1:0] f_prx, f_pry;
  logic [1:0]           f_region;

  assign e_last = e_carry[TF];

  always_comb begin
    case (e_last.region)
      psdc_pkg::REGION_INTERIOR: tq_f = e_tq[TF];
      psdc_pkg::REGION_PAST:     tq_f = TQW'(1) << TF;
      default:                   tq_f = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_sx     <= e_last.sx;
      f_sy     <= e_last.sy;
      f_px     <= e_last.px;
      f_py     <= e_last.py;
      f_region <= e_last.region;
      f_prx    <= $signed({1'b0, tq_f}) * e_last.ddx;
      f_pry    <= $signed({1'b0, tq_f}) * e_last.ddy;
    end
  end

  // stage G: closest point
  logic signed [PXW-1:0] shx, shy;
  logic signed [CW-1:0]  g_cx, g_cy, g_px, g_py;
  logic [1:0]            g_region;

  assign shx = f_prx >>> TF;
  assign shy = f_pry >>> TF;

  always_ff @(posedge clk) begin
    if (en) begin
      g_cx     <= f_sx + $signed(shx[CW-1:0]);
      g_cy     <= f_sy + $signed(shy[CW-1:0]);
      g_px     <= f_px;
      g_py     <= f_py;
      g_region <= f_region;
    end
  end

  // stage H: offsets to the query point
  sq_carry_t            h_carry;
  logic signed [DW-1:0] h_ex, h_ey;
  always_ff @(posedge clk) begin
    if (en) begin
      h_carry.cx     <= g_cx;
      h_carry.cy     <= g_cy;
      h_carry.region <= g_region;
      h_ex           <= {g_cx[CW-1], g_cx} - {g_px[CW-1], g_px};
      h_ey           <= {g_cy[CW-1], g_cy} - {g_py[CW-1], g_py};
    end
  end

  // stage I: squares
  sq_carry_t              i_carry;
  logic signed [2*DW-1:0] i_exx, i_eyy;
  always_ff @(posedge clk) begin
    if (en) begin
      i_carry <= h_carry;
      i_exx   <= h_ex * h_ex;
      i_eyy   <= h_ey * h_ey;
    end
  end

  // stage J: squared distance
  sq_carry_t     j_carry;
  logic [XW-1:0] j_x;
  always_ff @(posedge clk) begin
    if (en) begin
      j_carry <= i_carry;
      j_x     <= XW'({1'b0, i_exx} + {1'b0, i_eyy});
    end
  end

  // stage S: digit-by-digit square root, one root bit a stage
  sq_carry_t     s_carry [0:SW-1];
  logic [RW-1:0] s_rem   [0:SW-1];
  logic [SW-1:0] s_root  [0:SW-1];
  logic [XW-1:0] s_x     [0:SW-1];

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [XW-1:0] x_in;
    sq_carry_t     c_in;
    logic [RW+1:0] rs;
    logic [RW+1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = j_x;
      assign c_in    = j_carry;
    end else begin : g_rest
      assign rem_in  = s_rem[i-1];
      assign root_in = s_root[i-1];
      assign x_in    = s_x[i-1];
      assign c_in    = s_carry[i-1];
    end

    assign rs    = {rem_in, x_in[XW-1:XW-2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        s_carry[i] <= c_in;
        s_rem[i]   <= ge ? RW'(rs - trial) : rs[RW-1:0];
        s_root[i]  <= {root_in[SW-2:0], ge};
        s_x[i]     <= {x_in[XW-3:0], 2'b00};
      end
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {{OPAD{1'b0}}, s_carry[SW-1].cy, s_carry[SW-1].cx, s_root[SW-1]};
  assign m_tuser  = s_carry[SW-1].region;

endmodule

// ----- design/psdc_checker.sv -----
// ----------------------------------------------------------------------------
// psdc_checker
// Port-level checks for the point-to-segment closest point block.
// ----------------------------------------------------------------------------
`include "point_segment_distance_closest_top_macros.svh"

module psdc_checker #(
  parameter int OUT_W = 80
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [1:0]       m_tuser
);

  `PSDC_ASSERT_IMPLY(a_ready_follows_out, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready))
  `PSDC_ASSERT_NEXT(a_valid_holds, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `PSDC_ASSERT_NEXT(a_item_holds, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
  `PSDC_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !m_tvalid)

endmodule

bind point_segment_distance_closest_top psdc_checker #(
  .OUT_W(((3*COORD_WIDTH+2+7)/8)*8)
) u_psdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
